### design/stake_weighted_lottery_select_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stake-weighted lottery select block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STAKE_WEIGHTED_LOTTERY_SELECT_ASSERT_SVH
`define STAKE_WEIGHTED_LOTTERY_SELECT_ASSERT_SVH

// Condition and consequence in the same cycle
`define SWLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition
`define SWLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/swls_pkg.sv
// ----------------------------------------------------------------------------
// swls_pkg
// Types, constants and helpers shared by the lottery select modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swls_pkg;

  // Table geometry
  localparam int NUM_PARTICIPANTS = 4;
  localparam int STAKE_BITS       = 24;
  localparam int IDX_W            = $clog2(NUM_PARTICIPANTS);
  localparam int CNT_W            = IDX_W + 1;
  localparam int TOTAL_W          = STAKE_BITS + IDX_W;

  // Field widths
  localparam int WORD_W   = 31;
  localparam int REWARD_W = 16;
  localparam int BLK_W    = 16;
  localparam int SEL_W    = 2;
  localparam int WIN_W    = 24;
  localparam int STEP_W   = $clog2(WORD_W + 1);
  localparam int ADD_W    = ((STAKE_BITS > REWARD_W) ? STAKE_BITS : REWARD_W) + 1;

  typedef logic [STAKE_BITS-1:0] stake_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [TOTAL_W-1:0]    total_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [REWARD_W-1:0]   reward_t;
  typedef logic [BLK_W-1:0]      blk_t;
  typedef logic [SEL_W-1:0]      sel_t;
  typedef logic [WIN_W-1:0]      win_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [ADD_W-1:0]      add_t;

  // Reset values
  localparam stake_t  STAKE_MAX     = {STAKE_BITS{1'b1}};
  localparam stake_t  INIT_STAKE_0  = STAKE_BITS'(50);
  localparam stake_t  INIT_STAKE_1  = STAKE_BITS'(30);
  localparam stake_t  INIT_STAKE_2  = STAKE_BITS'(20);
  localparam reward_t REWARD_RESET  = REWARD_W'(10);
  localparam blk_t    COUNTER_RESET = BLK_W'(1);

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MOD,
    S_SCAN,
    S_WRITE,
    S_DONE
  } swls_state_t;

  // Stake memory access request
  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   we;
    idx_t   wr_addr;
    stake_t wr_data;
  } swls_ram_req_t;

  // Remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } swls_div_sts_t;

  // Stake an entry holds before its first write
  function automatic stake_t init_stake(input idx_t idx);
    stake_t v;
    v = '0;
    if (int'(idx) == 0) begin
      v = INIT_STAKE_0;
    end else if (int'(idx) == 1) begin
      v = INIT_STAKE_1;
    end else if (int'(idx) == 2) begin
      v = INIT_STAKE_2;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### design/swls_if.sv
// ----------------------------------------------------------------------------
// swls_if
// Valid/ready channels for selection requests and selection results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swls_in_if;
  import swls_pkg::*;
  logic  valid;
  logic  ready;
  word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface swls_out_if;
  import swls_pkg::*;
  logic valid;
  logic ready;
  sel_t selected_index;
  win_t winner_stake;
  blk_t block_number;
  logic no_stake;

  modport source (output valid, output selected_index, output winner_stake,
                  output block_number, output no_stake, input ready);
  modport sink   (input valid, input selected_index, input winner_stake,
                  input block_number, input no_stake, output ready);
endinterface

`default_nettype wire

### design/swls_stake_ram.sv
// ----------------------------------------------------------------------------
// swls_stake_ram
// Stake table memory: one write and one registered read per cycle, with
// per-entry valid bits so untouched entries read their reset stake.
// ----------------------------------------------------------------------------
`default_nettype none

module swls_stake_ram (
  input  logic                    clk,
  input  logic                    rst_n,
  input  swls_pkg::swls_ram_req_t req,
  output swls_pkg::stake_t        rd_data
);
  import swls_pkg::*;

  stake_t mem [NUM_PARTICIPANTS];
  logic [NUM_PARTICIPANTS-1:0] valid_r;
  stake_t rd_data_r;

  // Mark entries as written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port, forward a same-entry write
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.we && (req.wr_addr == req.rd_addr)) begin
        rd_data_r <= req.wr_data;
      end else if (valid_r[req.rd_addr]) begin
        rd_data_r <= mem[req.rd_addr];
      end else begin
        rd_data_r <= init_stake(req.rd_addr);
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/swls_mod_unit.sv
// ----------------------------------------------------------------------------
// swls_mod_unit
// Restoring remainder unit: reduces the random word modulo the total stake,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swls_mod_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  swls_pkg::word_t         dividend,
  input  swls_pkg::total_t        divisor,
  output swls_pkg::swls_div_sts_t sts,
  output swls_pkg::total_t        rem
);
  import swls_pkg::*;

  logic   busy_r;
  logic   done_r;
  step_t  step_r;
  word_t  dvd_r;
  total_t div_r;
  total_t rem_r;

  logic [TOTAL_W:0] shifted;
  logic [TOTAL_W:0] diff;
  logic             fits;

  // One restoring step
  always_comb begin
    shifted = {rem_r, dvd_r[WORD_W-1]};
    diff    = shifted - {1'b0, div_r};
    fits    = shifted >= {1'b0, div_r};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(WORD_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
      dvd_r <= {dvd_r[WORD_W-2:0], 1'b0};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;

endmodule

`default_nettype wire

### design/stake_weighted_lottery_select.sv
// ----------------------------------------------------------------------------
// stake_weighted_lottery_select
// Each request picks one of four participants with probability proportional
// to its stake and adds the configured reward (saturating) to the winner's stake.
// The random word is reduced modulo the total stake and the first entry whose
// running stake sum exceeds it wins. A request runs as a sweep of the stake
// memory to total the stakes, 31 steps of the serial remainder unit, a second
// sweep to find the winner, then a write-back and the result. The stake memory
// gives one read per cycle. One request is worked on at a time, and a finished
// result waits in the output register while the next request is accepted.
// With zero total stake the result comes with no_stake set, index zero, no
// reward and the block number unchanged. block_number starts at one and wraps
// after 65535.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stake_weighted_lottery_select_assert.svh"

module stake_weighted_lottery_select (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  swls_pkg::reward_t cfg_wdata,
  swls_in_if.sink           in_ch,
  swls_out_if.source        out_ch
);
  import swls_pkg::*;

  swls_state_t state_r, state_nxt;

  cnt_t    cnt_r;
  reward_t reward_r;
  blk_t    counter_r;
  word_t   word_r;
  total_t  total_r;
  total_t  pick_r;
  total_t  running_r;
  idx_t    win_idx_r;
  stake_t  win_stake_r;
  idx_t    res_idx_r;
  stake_t  res_stake_r;
  logic    res_nostake_r;

  logic out_valid_r;
  sel_t out_sel_r;
  win_t out_stake_r;
  blk_t out_blk_r;
  logic out_nostake_r;

  swls_ram_req_t ram_req;
  stake_t        ram_rd_data;
  swls_div_sts_t div_sts;
  total_t        div_rem;
  logic          div_start;
  logic          load_out;

  logic   in_fire;
  logic   out_free;
  logic   last;
  idx_t   ent_idx;
  total_t acc_sum;
  total_t run_sum;
  logic   hit;
  add_t   stake_add;
  stake_t sat_stake;

  swls_stake_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  swls_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (word_r),
    .divisor  (acc_sum),
    .sts      (div_sts),
    .rem      (div_rem)
  );

  // Handshake and datapath terms
  always_comb begin
    in_fire   = in_ch.valid && in_ch.ready;
    out_free  = !out_valid_r || out_ch.ready;
    last      = (cnt_r == CNT_W'(NUM_PARTICIPANTS));
    ent_idx   = IDX_W'(cnt_r - CNT_W'(1));
    acc_sum   = total_r + TOTAL_W'(ram_rd_data);
    run_sum   = running_r + TOTAL_W'(ram_rd_data);
    hit       = (cnt_r != '0) && (pick_r < run_sum);
    stake_add = ADD_W'(win_stake_r) + ADD_W'(reward_r);
    sat_stake = (stake_add > ADD_W'(STAKE_MAX)) ? STAKE_MAX
                                                : STAKE_BITS'(stake_add);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_SUM;
      end
      S_SUM: begin
        if (last) state_nxt = (acc_sum == '0) ? S_DONE : S_MOD;
      end
      S_MOD: begin
        if (div_sts.done) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ram_req.rd_en   = ((state_r == S_SUM) || (state_r == S_SCAN)) && !last;
    ram_req.rd_addr = cnt_r[IDX_W-1:0];
    ram_req.we      = (state_r == S_WRITE);
    ram_req.wr_addr = win_idx_r;
    ram_req.wr_data = sat_stake;
    div_start       = (state_r == S_SUM) && last && (acc_sum != '0);
    load_out        = (state_r == S_DONE) && out_free;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      reward_r    <= REWARD_RESET;
      counter_r   <= COUNTER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (((state_r == S_SUM) || (state_r == S_SCAN)) && !last) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (cfg_we) begin
        reward_r <= cfg_wdata;
      end
      if (load_out && !res_nostake_r) begin
        counter_r <= counter_r + BLK_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Capture the request and clear the total
    if (in_fire) begin
      word_r  <= in_ch.random_word;
      total_r <= '0;
    end
    // Accumulate the total stake
    if ((state_r == S_SUM) && (cnt_r != '0)) begin
      total_r <= acc_sum;
    end
    // Zero total: report entry zero without a reward
    if ((state_r == S_SUM) && last && (acc_sum == '0)) begin
      res_idx_r     <= '0;
      res_stake_r   <= '0;
      res_nostake_r <= 1'b1;
    end
    // Take the reduced word and restart the running sum
    if (state_r == S_MOD) begin
      running_r <= '0;
      if (div_sts.done) begin
        pick_r <= div_rem;
      end
    end
    // Walk the running sum and hold the winner
    if ((state_r == S_SCAN) && (cnt_r != '0)) begin
      running_r <= run_sum;
      if (hit) begin
        win_idx_r   <= ent_idx;
        win_stake_r <= ram_rd_data;
      end
    end
    // Reward the winner
    if (state_r == S_WRITE) begin
      res_idx_r     <= win_idx_r;
      res_stake_r   <= sat_stake;
      res_nostake_r <= 1'b0;
    end
    // Load the output register
    if (load_out) begin
      out_sel_r     <= SEL_W'(res_idx_r);
      out_stake_r   <= WIN_W'(res_stake_r);
      out_blk_r     <= counter_r;
      out_nostake_r <= res_nostake_r;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.selected_index = out_sel_r;
  assign out_ch.winner_stake   = out_stake_r;
  assign out_ch.block_number   = out_blk_r;
  assign out_ch.no_stake       = out_nostake_r;

  // Checks
  `SWLS_ASSERT_NEXT(a_accept_starts_sum, in_fire, state_r == S_SUM, "accept did not start sum")
  `SWLS_ASSERT_SAME(a_div_busy_in_mod, div_sts.busy, state_r == S_MOD, "divider busy outside mod")
  `SWLS_ASSERT_SAME(a_write_in_write, ram_req.we, state_r == S_WRITE, "stake write out of place")
  `SWLS_ASSERT_NEXT(a_nostake_ctr, load_out && res_nostake_r, $stable(counter_r), "counter moved")

endmodule

`default_nettype wire

### tb/tb_stake_weighted_lottery_select.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stake_weighted_lottery_select
// Self-checking bench for the stake-weighted lottery select block. A queue of
// random words feeds a valid/ready driver; a local stake table and block
// counter predict each draw, and a monitor compares every result field by
// field. Phases sweep the reward setting (reset value, zero, small, one,
// maximum) and the idling pattern on both channels, with one long output hold.
// ----------------------------------------------------------------------------

module tb_stake_weighted_lottery_select;
  import swls_pkg::*;

  localparam int  HALF_PERIOD    = 5;
  localparam int  RESET_CYCLES   = 5;
  localparam int  WATCHDOG_LIMIT = 3000;
  localparam int  LONG_HOLD      = 400;
  localparam int  DRAIN_CYCLES   = 60;
  localparam int  MAX_REPORTS    = 10;
  localparam word_t WORD_MAX     = {WORD_W{1'b1}};

  typedef struct packed {
    sel_t idx;
    win_t stake;
    blk_t blk;
    logic none;
  } draw_result_t;

  logic    clk;
  logic    rst_n;
  logic    cfg_we;
  reward_t cfg_wdata;

  swls_in_if  in_ch ();
  swls_out_if out_ch ();

  stake_weighted_lottery_select u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predicted block state
  stake_t  stakes_now [NUM_PARTICIPANTS];
  blk_t    blk_now;
  reward_t reward_now;

  word_t        queued_words [$];
  draw_result_t expected_draws [$];

  int   pushed_words;
  int   accepted_words;
  int   checked_results;
  int   mismatch_count;
  int   ceiling_hits;
  int   settings_used;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_seq;
  int   hold_seen;
  int   hold_left;
  int   idle_cycles;
  logic in_taken;

  // Clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Predict one draw and update the local stake table
  function automatic draw_result_t draw_winner(input word_t word);
    total_t       total;
    total_t       running;
    logic [31:0]  pick;
    logic [STAKE_BITS:0] grown;
    draw_result_t r;
    int           winner;
    logic         found;
    total = '0;
    for (int k = 0; k < NUM_PARTICIPANTS; k++) begin
      total = total + total_t'(stakes_now[k]);
    end
    if (total == '0) begin
      r.idx   = '0;
      r.stake = win_t'(stakes_now[0]);
      r.blk   = blk_now;
      r.none  = 1'b1;
      return r;
    end
    pick    = {1'b0, word} % 32'(total);
    running = '0;
    winner  = 0;
    found   = 1'b0;
    for (int k = 0; k < NUM_PARTICIPANTS; k++) begin
      running = running + total_t'(stakes_now[k]);
      if (!found && pick < 32'(running)) begin
        winner = k;
        found  = 1'b1;
      end
    end
    grown = {1'b0, stakes_now[winner]} + (STAKE_BITS+1)'(reward_now);
    if (grown > {1'b0, STAKE_MAX}) begin
      grown = {1'b0, STAKE_MAX};
    end
    stakes_now[winner] = grown[STAKE_BITS-1:0];
    r.idx   = sel_t'(winner);
    r.stake = win_t'(grown[STAKE_BITS-1:0]);
    r.blk   = blk_now;
    r.none  = 1'b0;
    blk_now = blk_now + BLK_W'(1);
    return r;
  endfunction

  task automatic note_mismatch(input string why, input draw_result_t want,
                               input draw_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch (%s): exp idx=%0d stake=%0d blk=%0d none=%0b",
               $realtime, why, want.idx, want.stake, want.blk, want.none);
      $display("[%0t]                  got idx=%0d stake=%0d blk=%0d none=%0b",
               $realtime, got.idx, got.stake, got.blk, got.none);
    end
  endtask

  // Drive the request channel; hold valid until the transaction is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (queued_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid       <= 1'b1;
        in_ch.random_word <= queued_words.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Drive result ready: random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen    <= hold_seq;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    draw_result_t want;
    draw_result_t got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        want = draw_winner(in_ch.random_word);
        if (want.stake == win_t'(STAKE_MAX)) begin
          ceiling_hits++;
        end
        expected_draws.insert(expected_draws.size(), want);
        accepted_words <= accepted_words + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.idx   = out_ch.selected_index;
        got.stake = out_ch.winner_stake;
        got.blk   = out_ch.block_number;
        got.none  = out_ch.no_stake;
        if (expected_draws.size() == 0) begin
          note_mismatch("result with no request pending", '0, got);
        end else begin
          want = expected_draws.pop_front();
          if (got !== want) begin
            note_mismatch("field mismatch", want, got);
          end
        end
        checked_results <= checked_results + 1;
      end
    end
  end

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reward(input reward_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we     <= 1'b0;
    reward_now  = value;
    settings_used++;
  endtask

  // Hold until every queued request has been answered
  task automatic wait_drained();
    while (checked_results != pushed_words) begin
      @(posedge clk);
    end
  endtask

  task automatic run_random_phase(input int count, input int idle_pct,
                                  input int stall_pct, input bit long_hold);
    word_t w;
    @(posedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 15))
        0, 1: begin
          w = word_t'($urandom_range(0, 255));
        end
        2: begin
          w = WORD_MAX - word_t'($urandom_range(0, 3));
        end
        default: begin
          w = word_t'($urandom);
        end
      endcase
      queued_words.insert(queued_words.size(), w);
    end
    pushed_words += count;
    if (long_hold) begin
      hold_seq++;
    end
    wait_drained();
  endtask

  initial begin
    word_t directed [$];
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.random_word = '0;
    out_ch.ready      = 1'b0;
    pushed_words      = 0;
    accepted_words    = 0;
    checked_results   = 0;
    mismatch_count    = 0;
    ceiling_hits      = 0;
    settings_used     = 1;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_seq          = 0;
    hold_seen         = 0;
    hold_left         = 0;
    idle_cycles       = 0;
    in_taken          = 1'b0;

    // Reset state of the prediction
    stakes_now[0] = INIT_STAKE_0;
    stakes_now[1] = INIT_STAKE_1;
    stakes_now[2] = INIT_STAKE_2;
    for (int k = 3; k < NUM_PARTICIPANTS; k++) begin
      stakes_now[k] = '0;
    end
    blk_now    = COUNTER_RESET;
    reward_now = REWARD_RESET;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: word extremes, alternating bits, and picks on entry edges
    directed = '{word_t'(0), word_t'(1), word_t'(49), word_t'(50), word_t'(79),
                 word_t'(80), word_t'(99), word_t'(100), WORD_MAX,
                 WORD_MAX - word_t'(1),
                 word_t'(31'h2AAA_AAAA), word_t'(31'h5555_5555),
                 word_t'(31'h4000_0000), word_t'(129)};
    @(posedge clk);
    foreach (directed[k]) begin
      queued_words.insert(queued_words.size(), directed[k]);
    end
    pushed_words += directed.size();
    wait_drained();

    // Reward zero, no idling
    write_reward('0);
    run_random_phase(80, 0, 0, 1'b0);

    // Small random reward, sender idling
    write_reward(reward_t'($urandom_range(1, 500)));
    run_random_phase(80, 67, 0, 1'b0);

    // Reward one, receiver stalling, with a long hold to back up the input
    write_reward(reward_t'(1));
    run_random_phase(80, 0, 67, 1'b1);

    // Maximum reward drives the leading stake to its ceiling
    write_reward({REWARD_W{1'b1}});
    run_random_phase(350, 35, 35, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_draws.size() != 0) begin
      mismatch_count += expected_draws.size();
      $display("%0d expected results never arrived", expected_draws.size());
    end

    $display("ran %0d selection requests under %0d reward settings and four idle patterns",
             pushed_words, settings_used);
    $display("%0d results at the stake ceiling, %0d mismatches", ceiling_hits,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### stake_weighted_lottery_select.f
+incdir+design
design/swls_pkg.sv
design/swls_if.sv
design/swls_stake_ram.sv
design/swls_mod_unit.sv
design/stake_weighted_lottery_select.sv
tb/tb_stake_weighted_lottery_select.sv
